### rtl/bdda_pkg.sv
// Shared types, constants and calendar helpers for the business-day date adder.
// No dependencies; bdda_front, bdda_walk and the top level import this package.
package bdda_pkg;

  localparam int unsigned MAX_BUSINESS_DAYS_DEF = 4095;
  localparam int unsigned QUEUE_DEPTH_DEF       = 2;

  localparam logic [6:0]  WEEKEND_RESET = 7'd96;
  localparam logic [6:0]  ALL_WEEKEND   = 7'h7F;
  localparam logic [13:0] YEAR_LAST     = 14'd9999;

  // floor(x / 100) = (x * 5243) >> 19 for x below 16384
  localparam logic [12:0] RECIP100    = 13'd5243;
  localparam int unsigned RECIP100_SH = 19;
  // floor(x / 7) = (x * 9363) >> 16 for the weekday sums that occur
  localparam logic [13:0] RECIP7      = 14'd9363;
  localparam int unsigned RECIP7_SH   = 16;

  typedef struct packed {
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [11:0] business_days;
  } in_t;

  typedef struct packed {
    logic [4:0]  end_day;
    logic [3:0]  end_month;
    logic [13:0] end_year;
    logic [2:0]  end_weekday;
    logic        bad_date;
  } out_t;

  // Classified item handed from the front to the walker
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
    logic [1:0]  y4;    // year mod 4
    logic [6:0]  r100;  // year mod 100
    logic [8:0]  r400;  // year mod 400
    logic        bad;
  } item_t;

  function automatic logic is_leap(input logic [1:0] y4, input logic [6:0] r100,
                                   input logic [8:0] r400);
    return ((y4 == 2'd0) && (r100 != 7'd0)) || (r400 == 9'd0);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // (31 * mm) / 12 with March as month one of the shifted year
  function automatic logic [4:0] month_off(input logic [3:0] m);
    logic [4:0] off;
    unique case (m)
      4'd1:    off = 5'd28;
      4'd2:    off = 5'd31;
      4'd3:    off = 5'd2;
      4'd4:    off = 5'd5;
      4'd5:    off = 5'd7;
      4'd6:    off = 5'd10;
      4'd7:    off = 5'd12;
      4'd8:    off = 5'd15;
      4'd9:    off = 5'd18;
      4'd10:   off = 5'd20;
      4'd11:   off = 5'd23;
      4'd12:   off = 5'd25;
      default: off = 5'd0;
    endcase
    return off;
  endfunction

endpackage

### rtl/bdda_front.sv
// Front end: takes a start date, checks it, works out its weekday and year residues.
// Depends on bdda_pkg; feeds bdda_queue.
module bdda_front #(
  parameter int unsigned MAX_BUSINESS_DAYS = bdda_pkg::MAX_BUSINESS_DAYS_DEF,
  parameter int unsigned CNT_W             = $clog2(MAX_BUSINESS_DAYS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  bdda_pkg::in_t        in_data,
  output logic                 busy,
  output logic                 push,
  output bdda_pkg::item_t      push_item,
  output logic [CNT_W-1:0]     push_cnt,
  input  logic                 full
);
  import bdda_pkg::*;

  localparam int unsigned WIDE_W = (CNT_W > 12) ? CNT_W : 12;

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_SUM, F_MOD, F_PUSH} fstate_t;

  fstate_t            state_r, state_nxt;
  in_t                in_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [13:0]        yy_r;
  logic [26:0]        py_r, pyy_r;
  logic [13:0]        sum_r;
  logic [27:0]        pmod_r;
  item_t              item_r;

  logic               accept;
  logic [WIDE_W-1:0]  n_wide, n_sat;
  logic [13:0]        yy;
  logic [7:0]         q100y, q100yy;
  logic [13:0]        r100_full;
  logic [6:0]         r100;
  logic [8:0]         r400;
  logic               leap, bad;
  logic [4:0]         mlen;
  logic [14:0]        sum;
  logic [11:0]        q7;
  logic [13:0]        wd_full;

  assign accept = start && (state_r == F_IDLE);
  assign busy   = (state_r != F_IDLE);

  always_comb begin
    n_wide = WIDE_W'(in_data.business_days);
    n_sat  = (n_wide > WIDE_W'(MAX_BUSINESS_DAYS)) ? WIDE_W'(MAX_BUSINESS_DAYS) : n_wide;

    // shifted year: January and February belong to the previous year
    yy = (in_r.start_month <= 4'd2) ? (in_r.start_year - 14'd1) : in_r.start_year;

    q100y     = py_r[RECIP100_SH +: 8];
    q100yy    = pyy_r[RECIP100_SH +: 8];
    r100_full = in_r.start_year - (14'(q100y) * 14'd100);
    r100      = r100_full[6:0];
    r400      = 9'(r100) + (9'(q100y[1:0]) * 9'd100);
    leap      = is_leap(in_r.start_year[1:0], r100, r400);
    mlen      = month_len(in_r.start_month, leap);
    bad       = (in_r.start_month < 4'd1) || (in_r.start_month > 4'd12)
             || (in_r.start_year < 14'd1) || (in_r.start_year > YEAR_LAST)
             || (in_r.start_day < 5'd1) || (in_r.start_day > mlen);
    sum       = 15'(in_r.start_day) + 15'(yy_r) + 15'(yy_r >> 2) - 15'(q100yy)
              + 15'(q100yy >> 2) + 15'(month_off(in_r.start_month));

    q7      = pmod_r[RECIP7_SH +: 12];
    wd_full = sum_r - (14'(q7) * 14'd7);

    push      = (state_r == F_PUSH) && !full;
    push_item = item_r;
    push_item.weekday = item_r.bad ? 3'd0 : wd_full[2:0];
    push_cnt  = cnt_r;

    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (accept) state_nxt = F_MUL;
      F_MUL:   state_nxt = F_SUM;
      F_SUM:   state_nxt = F_MOD;
      F_MOD:   state_nxt = F_PUSH;
      F_PUSH:  if (!full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (accept) begin
      in_r  <= in_data;
      cnt_r <= n_sat[CNT_W-1:0];
    end
    if (state_r == F_MUL) begin
      yy_r  <= yy;
      py_r  <= 27'(in_r.start_year) * 27'(RECIP100);
      pyy_r <= 27'(yy) * 27'(RECIP100);
    end
    if (state_r == F_SUM) begin
      sum_r        <= sum[13:0];
      item_r.day   <= in_r.start_day;
      item_r.month <= in_r.start_month;
      item_r.year  <= in_r.start_year;
      item_r.weekday <= 3'd0;
      item_r.y4    <= in_r.start_year[1:0];
      item_r.r100  <= r100;
      item_r.r400  <= r400;
      item_r.bad   <= bad;
    end
    if (state_r == F_MOD) begin
      pmod_r <= 28'(sum_r) * 28'(RECIP7);
    end
  end

endmodule

### rtl/bdda_queue.sv
// Short first-in first-out queue between the front end and the walker.
// Depends on nothing but its parameters.
module bdda_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] fill_r;

  assign full    = (fill_r == CNT_W'(DEPTH));
  assign empty   = (fill_r == '0);
  assign rd_data = slot_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop)      fill_r <= fill_r + CNT_W'(1);
      else if (pop && !push) fill_r <= fill_r - CNT_W'(1);
    end
    if (push) slot_r[wr_ptr_r] <= wr_data;
  end

endmodule

### rtl/bdda_walk.sv
// Back end: walks the calendar one day per cycle and emits the result beat.
// Depends on bdda_pkg; drains bdda_queue.
module bdda_walk #(
  parameter int unsigned CNT_W = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [6:0]           weekend_mask,
  input  logic                 empty,
  output logic                 pop,
  input  bdda_pkg::item_t      pop_item,
  input  logic [CNT_W-1:0]     pop_cnt,
  output logic                 out_valid,
  output bdda_pkg::out_t       out_data
);
  import bdda_pkg::*;

  typedef enum logic {B_IDLE, B_WALK} bstate_t;

  bstate_t           state_r;
  logic [4:0]        day_r;
  logic [3:0]        month_r;
  logic [13:0]       year_r;
  logic [2:0]        wd_r;
  logic [1:0]        y4_r;
  logic [6:0]        r100_r;
  logic [8:0]        r400_r;
  logic [CNT_W-1:0]  left_r;
  logic              out_valid_r;
  out_t              out_r;

  logic [7:0]        mask_ext;
  logic              weekend, done;
  logic [4:0]        mlen;

  assign mask_ext  = {1'b0, weekend_mask};
  assign weekend   = mask_ext[wd_r];
  assign done      = (left_r == '0) && !weekend;
  assign mlen      = month_len(month_r, is_leap(y4_r, r100_r, r400_r));
  assign pop       = (state_r == B_IDLE) && !empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      day_r       <= 5'd1;
      month_r     <= 4'd1;
      year_r      <= 14'd1;
      wd_r        <= 3'd0;
      y4_r        <= 2'd1;
      r100_r      <= 7'd1;
      r400_r      <= 9'd1;
      left_r      <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (pop) begin
            if (pop_item.bad) begin
              // impossible date: hand it straight back, walk state untouched
              out_valid_r <= 1'b1;
              out_r <= '{end_day: pop_item.day, end_month: pop_item.month,
                         end_year: pop_item.year, end_weekday: 3'd0, bad_date: 1'b1};
            end else begin
              day_r   <= pop_item.day;
              month_r <= pop_item.month;
              year_r  <= pop_item.year;
              wd_r    <= pop_item.weekday;
              y4_r    <= pop_item.y4;
              r100_r  <= pop_item.r100;
              r400_r  <= pop_item.r400;
              left_r  <= pop_cnt;
              state_r <= B_WALK;
            end
          end
        end
        B_WALK: begin
          if (done) begin
            out_valid_r <= 1'b1;
            out_r <= '{end_day: day_r, end_month: month_r, end_year: year_r,
                       end_weekday: wd_r, bad_date: 1'b0};
            state_r <= B_IDLE;
          end else begin
            // weekend days cost nothing; leading and trailing ones fall out here too
            if (!weekend) left_r <= left_r - CNT_W'(1);
            wd_r <= (wd_r == 3'd6) ? 3'd0 : wd_r + 3'd1;
            if (day_r >= mlen) begin
              day_r <= 5'd1;
              if (month_r >= 4'd12) begin
                month_r <= 4'd1;
                year_r  <= year_r + 14'd1;
                y4_r    <= y4_r + 2'd1;
                r100_r  <= (r100_r == 7'd99)  ? 7'd0 : r100_r + 7'd1;
                r400_r  <= (r400_r == 9'd399) ? 9'd0 : r400_r + 9'd1;
              end else begin
                month_r <= month_r + 4'd1;
              end
            end else begin
              day_r <= day_r + 5'd1;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

### rtl/business_day_date_adder_top.sv
// Top level of the business-day date adder: weekend register, front end, queue, walker.
// Depends on bdda_pkg, bdda_front, bdda_queue and bdda_walk.
//
// Use:
//   Input: drive in_data and raise start; the beat is taken on an edge where busy is low.
//   busy stays high while the front end checks the date and works out its weekday,
//   and longer if the queue to the walker is full.
//   Output: each result is a single-cycle beat on out_data marked by out_valid.
//   The receiver cannot stall, so results are never held; they come out in input order.
//   Configuration: write the 7-bit weekend mask on cfg_data with cfg_valid; cfg_ready
//   is always high. Write it only while no item is in flight. An all-ones mask counts
//   as no weekend at all.
// Walk: the walker steps one calendar day per cycle while it walks; weekend days are
//   stepped over without counting against the business days. The walker's
//   one-day-per-cycle step sets the rate; the front end can classify the next items
//   meanwhile, as long as the queue has room.
//   An impossible start date is returned unchanged with bad_date set, without a walk.
// Reset: synchronous, active low; the weekend mask returns to Friday and Saturday and
//   the queue empties.
module business_day_date_adder_top #(
  parameter int unsigned MAX_BUSINESS_DAYS = bdda_pkg::MAX_BUSINESS_DAYS_DEF,
  parameter int unsigned QUEUE_DEPTH       = bdda_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  bdda_pkg::in_t   in_data,
  output logic            out_valid,
  output bdda_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [6:0]      cfg_data
);
  import bdda_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_BUSINESS_DAYS + 1);
  localparam int unsigned Q_W   = $bits(item_t) + CNT_W;

  logic [6:0]        weekend_mask_r;
  logic [6:0]        mask_eff;
  logic [7:0]        mask_eff_ext;

  logic              push, pop, full, empty;
  item_t             push_item, pop_item;
  logic [CNT_W-1:0]  push_cnt, pop_cnt;
  logic [Q_W-1:0]    q_rd;

  assign cfg_ready    = 1'b1;
  // all seven days weekend would never end: treat it as no weekend
  assign mask_eff     = (weekend_mask_r == ALL_WEEKEND) ? 7'd0 : weekend_mask_r;
  assign mask_eff_ext = {1'b0, mask_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weekend_mask_r <= WEEKEND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      weekend_mask_r <= cfg_data;
    end
  end

  bdda_front #(
    .MAX_BUSINESS_DAYS (MAX_BUSINESS_DAYS),
    .CNT_W             (CNT_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .push      (push),
    .push_item (push_item),
    .push_cnt  (push_cnt),
    .full      (full)
  );

  bdda_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data ({push_cnt, push_item}),
    .full    (full),
    .pop     (pop),
    .rd_data (q_rd),
    .empty   (empty)
  );

  assign pop_item = q_rd[$bits(item_t)-1:0];
  assign pop_cnt  = q_rd[Q_W-1 -: CNT_W];

  bdda_walk #(
    .CNT_W (CNT_W)
  ) u_walk (
    .clk          (clk),
    .rst_n        (rst_n),
    .weekend_mask (mask_eff),
    .empty        (empty),
    .pop          (pop),
    .pop_item     (pop_item),
    .pop_cnt      (pop_cnt),
    .out_valid    (out_valid),
    .out_data     (out_data)
  );

  // a flagged date never carries a weekday
  a_bad_weekday: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_date |-> out_data.end_weekday == 3'd0)
    else $error("bad date beat with non-zero weekday");

  // a good result never lands on a weekend day
  a_no_weekend_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.bad_date |-> !mask_eff_ext[out_data.end_weekday])
    else $error("result falls on a weekend day");

  // a good result has a non-zero day and a month from 1 to 12
  a_real_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.bad_date |->
      out_data.end_day != 5'd0 && out_data.end_month != 4'd0 && out_data.end_month <= 4'd12)
    else $error("result date out of range");

  // a taken beat keeps the front end busy for its classification
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("front end free straight after taking a beat");

  // the front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

endmodule
